// File: design/rational_alu_with_reduction_top_assert.svh
// Assertion macros shared by the rational ALU modules
`ifndef RATIONAL_ALU_WITH_REDUCTION_TOP_ASSERT_SVH
`define RATIONAL_ALU_WITH_REDUCTION_TOP_ASSERT_SVH
// implication checked every cycle outside reset
`define RA_ASSERT_IMP(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define RA_ASSERT_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

// File: design/ra_pkg.sv
// Shared types and constants for the rational ALU
package ra_pkg;
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_CMP = 3'd4;
  localparam int MAG_W = 33;
  localparam int CNT_W = 6;

  typedef struct packed {
    logic load;     // capture operands
    logic mul1;     // first products
    logic mul2;     // combine products
    logic gcd_init; // start Euclid
    logic mod_init; // start one remainder
    logic mod_step; // one bit of remainder
    logic mod_done; // x<=y, y<=r
    logic div_init; // start quotient divisions
    logic div_step; // one quotient bit
    logic finish;   // form result
  } ra_cmd_t;

  typedef struct packed {
    logic bad;    // error case
    logic is_cmp;
    logic y_zero;
  } ra_stat_t;
endpackage

// File: design/rational_alu_with_reduction_top.sv
// Rational ALU top level: sequencer, datapath and output register
// Compare and error items go straight to the result; arithmetic items run the
// Euclid steps and then the quotient divisions before the result forms.
// One item at a time: a new input is taken only after the result has loaded.
// The sequencer iterates a bit-serial remainder unit for each Euclid step.
// Reset (rst, synchronous): sequencer idle, output register empty.
module rational_alu_with_reduction_top (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  input  logic [63:0] s_tdata, // a_num, a_den, b_num, b_den from bit 0
  input  logic [2:0] s_tuser,  // action
  output logic m_tvalid,
  input  logic m_tready,
  output logic [63:0] m_tdata, // res_num, res_den, cmp_result from bit 0
  output logic m_tuser         // error
);
  ra_pkg::ra_cmd_t cmd;
  ra_pkg::ra_stat_t stat;
  logic busy, in_fire;
  logic signed [31:0] res_num;
  logic [29:0] res_den;
  logic signed [1:0] cmp_result;
  logic error;

  assign s_tready = !busy;
  assign in_fire = s_tvalid && s_tready;

  ra_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_busy(m_tvalid && !m_tready),
    .stat(stat), .cmd(cmd), .busy(busy)
  );

  ra_dp u_dp (
    .clk(clk), .cmd(cmd), .action(s_tuser),
    .a_num(s_tdata[15:0]), .a_den(s_tdata[31:16]),
    .b_num(s_tdata[47:32]), .b_den(s_tdata[63:48]),
    .stat(stat), .res_num(res_num), .res_den(res_den),
    .cmp_result(cmp_result), .error(error)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {cmp_result, res_den, res_num};
  assign m_tuser = error;

`include "rational_alu_with_reduction_top_assert.svh"
  `RA_ASSERT_IMP(a_no_overwrite, clk, rst, m_tvalid && !m_tready, !cmd.finish)
  `RA_ASSERT_NEXT(a_fin_valid, clk, rst, cmd.finish, m_tvalid)
  `RA_ASSERT_IMP(a_busy_noacc, clk, rst, busy, !s_tready)
endmodule

// File: design/ra_ctrl.sv
// Sequencer for the rational ALU
module ra_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  ra_pkg::ra_stat_t stat,
  output ra_pkg::ra_cmd_t cmd,
  output logic busy
);
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL1 = 4'd1;
  localparam logic [3:0] S_MUL2 = 4'd2;
  localparam logic [3:0] S_GCD  = 4'd3;
  localparam logic [3:0] S_MOD  = 4'd4;
  localparam logic [3:0] S_MODD = 4'd5;
  localparam logic [3:0] S_DIVI = 4'd6;
  localparam logic [3:0] S_DIV  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state, state_next;
  logic [ra_pkg::CNT_W-1:0] cnt, cnt_next;

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        state_next = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1 = 1'b1;
        state_next = S_MUL2;
      end
      S_MUL2: begin
        cmd.mul2 = 1'b1;
        state_next = (stat.bad || stat.is_cmp) ? S_FIN : S_GCD;
      end
      S_GCD: begin
        cmd.gcd_init = 1'b1;
        state_next = S_MOD;
        cnt_next = '0;
      end
      S_MOD: begin
        if (stat.y_zero) begin
          state_next = S_DIVI;
        end else begin
          cmd.mod_init = 1'b1;
          state_next = S_MODD;
          cnt_next = '0;
        end
      end
      S_MODD: begin
        if (cnt == ra_pkg::CNT_W'(ra_pkg::MAG_W)) begin
          cmd.mod_done = 1'b1;
          state_next = S_MOD;
        end else begin
          cmd.mod_step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        cnt_next = '0;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (cnt == ra_pkg::CNT_W'(ra_pkg::MAG_W)) begin
          state_next = S_FIN;
        end else begin
          cmd.div_step = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_FIN: if (!out_busy) begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  assign busy = (state != S_IDLE);

`include "rational_alu_with_reduction_top_assert.svh"
  `RA_ASSERT_IMP(a_load_idle, clk, rst, cmd.load, state == S_IDLE)
  `RA_ASSERT_NEXT(a_fin_idle, clk, rst, cmd.finish, state == S_IDLE)
  `RA_ASSERT_IMP(a_cnt_rng, clk, rst, state == S_MODD,
                 cnt <= ra_pkg::CNT_W'(ra_pkg::MAG_W))
endmodule

// File: design/ra_dp.sv
// Datapath: products, Euclid remainder and quotient by restoring shift-subtract
module ra_dp (
  input  logic clk,
  input  ra_pkg::ra_cmd_t cmd,
  input  logic [2:0] action,
  input  logic signed [15:0] a_num,
  input  logic signed [15:0] a_den,
  input  logic signed [15:0] b_num,
  input  logic signed [15:0] b_den,
  output ra_pkg::ra_stat_t stat,
  output logic signed [31:0] res_num,
  output logic [29:0] res_den,
  output logic signed [1:0] cmp_result,
  output logic error
);
  localparam int W = ra_pkg::MAG_W;
  logic [2:0] act;
  logic signed [16:0] an, ad, bn, bd;
  logic signed [33:0] p1, p2;
  logic [W-1:0] mnum, mden, gx, gy, rem, q0, q1, r0, r1;
  logic [W-1:0] sh;
  logic neg, bad, iscmp;
  logic signed [1:0] cmpv;
  logic signed [34:0] nsum;
  logic signed [33:0] dprod;
  logic [W:0] t0, t1, tm;

  assign bad = (ad == 0) || (bd == 0) || (act > ra_pkg::ACT_CMP) ||
               (act == ra_pkg::ACT_DIV && bn == 0);
  assign iscmp = (act == ra_pkg::ACT_CMP);
  assign stat.bad = bad;
  assign stat.is_cmp = iscmp;
  assign stat.y_zero = (gy == '0);

  assign tm = {rem, sh[W-1]};
  assign t0 = {r0, q0[W-1]};
  assign t1 = {r1, q1[W-1]};

  always_comb begin
    unique case (act)
      ra_pkg::ACT_ADD: nsum = 35'(p1) + 35'(p2);
      ra_pkg::ACT_SUB: nsum = 35'(p1) - 35'(p2);
      default:         nsum = 35'(p1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act <= action;
      an <= 17'(a_num); ad <= 17'(a_den);
      bn <= 17'(b_num); bd <= 17'(b_den);
    end
    if (cmd.mul1) begin
      if (act == ra_pkg::ACT_CMP) begin
        p1 <= (ad < 0 ? -an : an) * (bd < 0 ? -bd : bd);
        p2 <= (bd < 0 ? -bn : bn) * (ad < 0 ? -ad : ad);
      end else begin
        unique case (act)
          ra_pkg::ACT_MUL: p1 <= an * bn;
          default:         p1 <= an * bd;
        endcase
        p2 <= bn * ad;
      end
      unique case (act)
        ra_pkg::ACT_DIV: dprod <= ad * bn;
        default:         dprod <= ad * bd;
      endcase
    end
    if (cmd.mul2) begin
      mnum <= W'(nsum < 0 ? -nsum : nsum);
      mden <= W'(dprod < 0 ? -dprod : dprod);
      neg <= (nsum < 0) != (dprod < 0);
      cmpv <= (p1 > p2) ? 2'sd1 : ((p1 < p2) ? -2'sd1 : 2'sd0);
    end
    if (cmd.gcd_init) begin
      gx <= mnum;
      gy <= mden;
    end
    if (cmd.mod_init) begin
      rem <= '0;
      sh <= gx;
    end
    if (cmd.mod_step) begin
      sh <= sh << 1;
      rem <= (tm >= {1'b0, gy}) ? W'(tm - {1'b0, gy}) : tm[W-1:0];
    end
    if (cmd.mod_done) begin
      gx <= gy;
      gy <= rem;
    end
    if (cmd.div_init) begin
      q0 <= mnum; r0 <= '0;
      q1 <= mden; r1 <= '0;
    end
    if (cmd.div_step) begin
      if (t0 >= {1'b0, gx}) begin
        r0 <= W'(t0 - {1'b0, gx}); q0 <= {q0[W-2:0], 1'b1};
      end else begin
        r0 <= t0[W-1:0]; q0 <= {q0[W-2:0], 1'b0};
      end
      if (t1 >= {1'b0, gx}) begin
        r1 <= W'(t1 - {1'b0, gx}); q1 <= {q1[W-2:0], 1'b1};
      end else begin
        r1 <= t1[W-1:0]; q1 <= {q1[W-2:0], 1'b0};
      end
    end
    if (cmd.finish) begin
      error <= bad;
      if (bad) begin
        res_num <= '0; res_den <= '0; cmp_result <= '0;
      end else if (iscmp) begin
        res_num <= '0; res_den <= '0; cmp_result <= cmpv;
      end else if (q0 == '0) begin
        res_num <= '0; res_den <= 30'd1; cmp_result <= '0;
      end else begin
        res_num <= neg ? -q0[31:0] : q0[31:0];
        res_den <= q1[29:0];
        cmp_result <= '0;
      end
    end
  end
endmodule

// File: test/rational_alu_with_reduction_top_tb.sv
// Testbench for the rational ALU: directed table plus random fractions, scoreboard check
module rational_alu_with_reduction_top_tb;

  typedef struct packed {
    logic        error;
    logic [1:0]  cmp_result;
    logic [29:0] res_den;
    logic [31:0] res_num;
  } frac_res_t;

  typedef struct {
    logic [2:0]  act;
    logic [15:0] an, ad, bn, bd;
    bit          has_exp;
    frac_res_t   exp_res;
  } frac_row_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;
  logic m_tuser;

  frac_res_t result_q[$];
  int mismatches = 0;
  int rx_hold = 0;
  bit rx_on = 1;
  bit done_tx = 0;

  always #2 clk = ~clk;

  rational_alu_with_reduction_top u_dut (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tdata(s_tdata), .s_tuser(s_tuser), .m_tvalid(m_tvalid),
    .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
    longint unsigned r;
    while (y != 0) begin
      r = x % y;
      x = y;
      y = r;
    end
    return x;
  endfunction

  function automatic frac_res_t frac_predict(logic [2:0] act, logic [15:0] ian,
                                             logic [15:0] iad, logic [15:0] ibn,
                                             logic [15:0] ibd);
    frac_res_t r;
    longint an, ad, bn, bd, num, den, l, rr, sn;
    longint unsigned mn, md, g;
    bit neg;
    an = longint'($signed(ian));
    ad = longint'($signed(iad));
    bn = longint'($signed(ibn));
    bd = longint'($signed(ibd));
    r = '0;
    if (ad == 0 || bd == 0 || act > ra_pkg::ACT_CMP ||
        (act == ra_pkg::ACT_DIV && bn == 0)) begin
      r.error = 1;
      return r;
    end
    if (act == ra_pkg::ACT_CMP) begin
      if (ad < 0) begin an = -an; ad = -ad; end
      if (bd < 0) begin bn = -bn; bd = -bd; end
      l = an * bd;
      rr = bn * ad;
      r.cmp_result = (l > rr) ? 2'b01 : (l < rr) ? 2'b11 : 2'b00;
      return r;
    end
    case (act)
      ra_pkg::ACT_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
      ra_pkg::ACT_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
      ra_pkg::ACT_MUL: begin num = an * bn; den = ad * bd; end
      default: begin num = an * bd; den = ad * bn; end
    endcase
    mn = (num < 0) ? -num : num;
    md = (den < 0) ? -den : den;
    g = euclid_gcd(mn, md);
    mn = mn / g;
    md = md / g;
    neg = (num < 0) != (den < 0);
    if (mn == 0) begin
      neg = 0;
      md = 1;
    end
    sn = neg ? -longint'(mn) : longint'(mn);
    r.res_num = sn[31:0];
    r.res_den = md[29:0];
    return r;
  endfunction

  // valid stays high into the next transfer unless a gap follows
  task automatic send_frac(logic [2:0] act, logic [15:0] an, logic [15:0] ad,
                           logic [15:0] bn, logic [15:0] bd);
    result_q.push_back(frac_predict(act, an, ad, bn, bd));
    s_tuser <= act;
    s_tdata <= {bd, bn, ad, an};
    s_tvalid <= 1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 2) == 0) n = 0;
    if (n != 0) s_tvalid <= 0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'($urandom_range(0, 8)) - 16'd4;
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2: return 16'($urandom_range(0, 30)) - 16'd15;
      default: return 16'($urandom);
    endcase
  endfunction

  // receiver: short random stalls and an occasional long one
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (!rx_on) begin
      m_tready <= 1;
    end else if (rx_hold != 0) begin
      m_tready <= 0;
      rx_hold <= rx_hold - 1;
    end else if ($urandom_range(0, 99) == 0) begin
      m_tready <= 0;
      rx_hold <= $urandom_range(20, 80);
    end else begin
      m_tready <= ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    frac_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata};
      if (result_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = result_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp num=%0d den=%0d cmp=%0d err=%0d got num=%0d den=%0d cmp=%0d err=%0d",
                     $signed(want.res_num), want.res_den, $signed(want.cmp_result), want.error,
                     $signed(got.res_num), got.res_den, $signed(got.cmp_result), got.error);
        end
      end
    end
  end

  frac_row_t dir_rows[$];

  task automatic add_row(logic [2:0] act, logic [15:0] an, logic [15:0] ad,
                         logic [15:0] bn, logic [15:0] bd, bit has_exp, frac_res_t e);
    frac_row_t row;
    row.act = act; row.an = an; row.ad = ad; row.bn = bn; row.bd = bd;
    row.has_exp = has_exp; row.exp_res = e;
    dir_rows.push_back(row);
  endtask

  initial begin
    frac_res_t err_res, none;
    frac_res_t chk;
    logic [2:0] act;
    logic [15:0] an, ad, bn, bd;
    err_res = '0; err_res.error = 1;
    none = '0;
    chk = '0;

    add_row(ra_pkg::ACT_ADD, 16'd1, 16'd0, 16'd1, 16'd1, 1, err_res);
    add_row(ra_pkg::ACT_CMP, 16'd1, 16'd1, 16'd1, 16'd0, 1, err_res);
    add_row(ra_pkg::ACT_DIV, 16'd3, 16'd4, 16'd0, 16'd5, 1, err_res);
    add_row(3'd5, 16'd1, 16'd1, 16'd1, 16'd1, 1, err_res);
    add_row(3'd6, 16'd1, 16'd1, 16'd1, 16'd1, 1, err_res);
    add_row(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, err_res);
    chk.res_num = 0; chk.res_den = 1;
    add_row(ra_pkg::ACT_SUB, 16'd5, 16'd7, 16'd5, 16'd7, 1, chk);
    add_row(ra_pkg::ACT_MUL, 16'd0, 16'hfffd, 16'd9, 16'd4, 1, chk);
    chk = '0; chk.cmp_result = 2'b00;
    add_row(ra_pkg::ACT_CMP, 16'd1, 16'd2, 16'd2, 16'd4, 1, chk);
    chk.cmp_result = 2'b01;
    add_row(ra_pkg::ACT_CMP, 16'd1, 16'd2, 16'd1, 16'd3, 1, chk);
    chk.cmp_result = 2'b11;
    add_row(ra_pkg::ACT_CMP, 16'd1, 16'hfffe, 16'd1, 16'd3, 1, chk);
    add_row(ra_pkg::ACT_ADD, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 0, none);
    add_row(ra_pkg::ACT_ADD, 16'h7fff, 16'd1, 16'h7fff, 16'd1, 0, none);
    add_row(ra_pkg::ACT_SUB, 16'h8001, 16'd1, 16'h7fff, 16'd1, 0, none);
    add_row(ra_pkg::ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 0, none);
    add_row(ra_pkg::ACT_MUL, 16'h8000, 16'd1, 16'h8000, 16'd1, 0, none);
    add_row(ra_pkg::ACT_DIV, 16'h8000, 16'd1, 16'd1, 16'h8000, 0, none);
    add_row(ra_pkg::ACT_DIV, 16'h7fff, 16'h8001, 16'h8000, 16'h7ffe, 0, none);
    add_row(ra_pkg::ACT_ADD, 16'hffff, 16'hfffe, 16'd1, 16'h8000, 0, none);
    add_row(ra_pkg::ACT_CMP, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 0, none);
    add_row(ra_pkg::ACT_SUB, 16'h5555, 16'haaaa, 16'h0f0f, 16'hf0f0, 0, none);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].has_exp &&
          frac_predict(dir_rows[i].act, dir_rows[i].an, dir_rows[i].ad,
                       dir_rows[i].bn, dir_rows[i].bd) !== dir_rows[i].exp_res) begin
        mismatches++;
        $display("directed row %0d: predictor disagrees with table", i);
      end
      send_frac(dir_rows[i].act, dir_rows[i].an, dir_rows[i].ad, dir_rows[i].bn,
                dir_rows[i].bd);
      idle_gap();
    end
    s_tvalid <= 0;

    // hold the sender until the block has drained
    while (result_q.size() != 0) @(negedge clk);

    for (int i = 0; i < 1830; i++) begin
      act = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      an = rand_val(); bn = rand_val();
      ad = rand_val(); bd = rand_val();
      if ($urandom_range(0, 24) != 0) begin
        if (ad == 0) ad = 16'd1;
        if (bd == 0) bd = 16'hffff;
      end
      rx_on = (i < 1500) || (i > 1700);
      send_frac(act, an, ad, bn, bd);
      if (i % 300 < 150) idle_gap();
    end
    s_tvalid <= 0;
    rx_on = 1;

    while (result_q.size() != 0) @(negedge clk);
    repeat (2000) @(negedge clk);
    if (mismatches == 0 && result_q.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #100000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule

// File: files.f
+incdir+design
design/ra_pkg.sv
design/ra_ctrl.sv
design/ra_dp.sv
design/rational_alu_with_reduction_top.sv
test/rational_alu_with_reduction_top_tb.sv
